/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define KEC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define KEC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/kec_pkg.sv */
package kec_pkg;

	localparam int unsigned NUM_KEYS   = 128;
	localparam int unsigned FIFO_DEPTH = 256;

	// key table address and scan counter widths
	localparam int unsigned KA_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int unsigned KCNT_W = $clog2(NUM_KEYS + 1);
	// event queue pointer width
	localparam int unsigned PTR_W  = $clog2(FIFO_DEPTH);
	// key table entry: live bit over 8-bit history
	localparam int unsigned KEY_ENT_W = 9;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_KEY   = 2'd2,
		CMD_SCAN  = 2'd3
	} cmd_t;

	localparam logic [7:0] ADDR_STATUS  = 8'h00;
	localparam logic [7:0] ADDR_CONTROL = 8'h01;
	localparam logic [7:0] ADDR_EVENT   = 8'h02;

	localparam int unsigned ACK_BIT    = 0;
	localparam int unsigned IRQ_EN_BIT = 0;
	localparam logic [7:0]  EV_RELEASE = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_KEY,
		ST_SCAN,
		ST_RESP
	} kec_state_t;

	typedef struct packed {
		logic            rd_en;
		logic [KA_W-1:0] rd_addr;
		logic            wr_en;
		logic [KA_W-1:0] wr_addr;
		logic            wr_live;
		logic [7:0]      wr_hist;
	} key_req_t;

	typedef struct packed {
		logic       live;
		logic [7:0] hist;
	} key_rsp_t;

	typedef struct packed {
		logic       push;
		logic [7:0] push_data;
		logic       pop;
	} q_req_t;

	typedef struct packed {
		logic       empty;
		logic       one_left;
		logic [7:0] rd_data;
	} q_rsp_t;

endpackage

/* rtl/kec_in_if.sv */
interface kec_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] address;
	logic [7:0] write_data;
	logic [6:0] key_index;
	logic       key_down;

	modport source (
		output valid, command, address, write_data, key_index, key_down,
		input  ready
	);
	modport sink (
		input  valid, command, address, write_data, key_index, key_down,
		output ready
	);
endinterface

/* rtl/kec_out_if.sv */
interface kec_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       irq_n;

	modport source (
		output valid, read_data, irq_n,
		input  ready
	);
	modport sink (
		input  valid, read_data, irq_n,
		output ready
	);
endinterface

/* rtl/kec_ram.sv */
module kec_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* rtl/kec_key_store.sv */
module kec_key_store (
	input  logic              clk,
	input  logic              arst_n,
	input  kec_pkg::key_req_t req,
	output kec_pkg::key_rsp_t rsp
);
	import kec_pkg::*;

	logic [NUM_KEYS-1:0]  valid_q;
	logic                 valid_s1;
	logic [KEY_ENT_W-1:0] ram_rdata;

	kec_ram #(
		.WIDTH(KEY_ENT_W),
		.DEPTH(NUM_KEYS)
	) u_ram (
		.clk   (clk),
		.we    (req.wr_en),
		.waddr (req.wr_addr),
		.wdata ({req.wr_live, req.wr_hist}),
		.re    (req.rd_en),
		.raddr (req.rd_addr),
		.rdata (ram_rdata)
	);

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				valid_s1 <= valid_q[req.rd_addr];
			end
		end
	end

	assign rsp.live = valid_s1 & ram_rdata[KEY_ENT_W-1];
	assign rsp.hist = valid_s1 ? ram_rdata[7:0] : 8'h00;
endmodule

/* rtl/kec_event_queue.sv */
module kec_event_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  kec_pkg::q_req_t req,
	output kec_pkg::q_rsp_t rsp
);
	import kec_pkg::*;

	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] head_nxt;
	logic [PTR_W-1:0] tail_nxt;
	logic [7:0]       ram_rdata;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (32'(p) == FIFO_DEPTH - 1) ? '0 : p + 1'b1;
	endfunction

	assign head_nxt = ptr_next(head_q);
	assign tail_nxt = ptr_next(tail_q);

	kec_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (req.push),
		.waddr (head_q),
		.wdata (req.push_data),
		.re    (req.pop),
		.raddr (tail_q),
		.rdata (ram_rdata)
	);

	// no overflow guard: head simply laps the tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (req.push) begin
				head_q <= head_nxt;
			end
			if (req.pop) begin
				tail_q <= tail_nxt;
			end
		end
	end

	assign rsp.empty    = (head_q == tail_q);
	assign rsp.one_left = (tail_nxt == head_q);
	assign rsp.rd_data  = ram_rdata;
endmodule

/* rtl/keyboard_event_controller_core.sv */
// Keyboard event controller behind a byte register bus. Each input transfer is one bus
// command (register read, register write, key state update or scan tick) and gives
// exactly one output transfer carrying the read byte and the interrupt line after the
// command. Items are handled one at a time. Writes and reads of status, control, unmapped
// addresses or an empty event queue go straight to the response state; an event pop
// from a non-empty queue (0x02) and a history read (0x80..0xFF) first wait on the
// registered read of the event memory or the key table; a key state update does a
// read-modify-write of its key table entry; a scan tick does one key table read and
// write-back per key. A new input transfer is taken as soon as the controller is
// back in idle, even while the previous result is still held in the output
// register. The key table is cleared by per-entry valid bits, so no clearing
// pass runs after reset.
// empty_code may only be written while no command is in progress.
`include "assert_macros.svh"

module keyboard_event_controller_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	kec_in_if.sink     req,
	kec_out_if.source  rsp
);
	import kec_pkg::*;

	// controller state
	kec_state_t state_q;
	kec_state_t next_state;

	// software visible registers and flags
	logic [7:0] empty_code_q;
	logic [7:0] control_q;
	logic       pending_q;
	logic       irq_flag_q;
	logic       irq_line_q;

	// captured command
	cmd_t            cmd_q;
	logic [KA_W-1:0] key_q;
	logic            down_q;
	logic [7:0]      res_q;

	// output register
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_irq_n_q;

	// scan walk: read stage counter and write-back stage
	logic [KCNT_W-1:0] scan_cnt_q;
	logic              scan_v_s1;
	logic [KA_W-1:0]   scan_idx_s1;

	key_req_t key_req;
	key_rsp_t key_rsp;
	q_req_t   q_req;
	q_rsp_t   q_rsp;

	logic       accept;
	logic       out_free;
	logic       key_ok;
	logic       hist_ok;
	logic       scan_issue;
	logic [7:0] scan_hist;
	logic       ev_push;
	logic [7:0] ev_byte;
	logic [7:0] imm_rd;
	logic       res_ld;
	logic [7:0] res_nxt;
	logic       pend_clr;

	kec_key_store u_keys (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (key_req),
		.rsp    (key_rsp)
	);

	kec_event_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (q_req),
		.rsp    (q_rsp)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid & req.ready;
	// output register can take a new result this cycle
	assign out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = out_data_q;
	assign rsp.irq_n     = out_irq_n_q;

	// range checks for key updates and history reads
	assign key_ok  = 32'(req.key_index) < NUM_KEYS;
	assign hist_ok = req.address[7] && (32'(req.address[6:0]) < NUM_KEYS);

	assign scan_issue = 32'(scan_cnt_q) < NUM_KEYS;

	// new history of the key in write-back: old history shifted, live bit in at bit 0
	assign scan_hist = {key_rsp.hist[6:0], key_rsp.live};
	// lowest two bits 01 is a press, 10 a release
	assign ev_push   = scan_v_s1 && (scan_hist[1] ^ scan_hist[0]);
	assign ev_byte   = scan_hist[1] ? (EV_RELEASE | 8'(scan_idx_s1)) : 8'(scan_idx_s1);

	// reads answered without touching a memory
	always_comb begin
		case (req.address)
			ADDR_STATUS:  imm_rd = {irq_flag_q, 6'b000000, pending_q};
			ADDR_CONTROL: imm_rd = control_q;
			ADDR_EVENT:   imm_rd = empty_code_q;
			default:      imm_rd = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= next_state;
		end
	end

	always_comb begin
		next_state = state_q;
		key_req    = '0;
		q_req      = '0;
		res_ld     = 1'b0;
		res_nxt    = 8'h00;
		pend_clr   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_ld     = 1'b1;
					next_state = ST_RESP;
					case (req.command)
						CMD_READ: begin
							res_nxt = imm_rd;
							if (req.address == ADDR_EVENT && !q_rsp.empty) begin
								// pop: pending drops when this takes the last entry
								q_req.pop  = 1'b1;
								pend_clr   = q_rsp.one_left;
								next_state = ST_POP;
							end else if (hist_ok) begin
								key_req.rd_en   = 1'b1;
								key_req.rd_addr = req.address[KA_W-1:0];
								next_state      = ST_KEY;
							end
						end
						CMD_WRITE: begin
							// register writes are done in the datapath below
						end
						CMD_KEY: begin
							if (key_ok) begin
								key_req.rd_en   = 1'b1;
								key_req.rd_addr = req.key_index[KA_W-1:0];
								next_state      = ST_KEY;
							end
						end
						default: begin
							next_state = ST_SCAN;
						end
					endcase
				end
			end
			ST_POP: begin
				res_ld     = 1'b1;
				res_nxt    = q_rsp.rd_data;
				next_state = ST_RESP;
			end
			ST_KEY: begin
				if (cmd_q == CMD_KEY) begin
					// write back the new live bit, history unchanged
					key_req.wr_en   = 1'b1;
					key_req.wr_addr = key_q;
					key_req.wr_live = down_q;
					key_req.wr_hist = key_rsp.hist;
				end else begin
					res_ld  = 1'b1;
					res_nxt = key_rsp.hist;
				end
				next_state = ST_RESP;
			end
			ST_SCAN: begin
				// read key n while key n-1 is written back
				if (scan_issue) begin
					key_req.rd_en   = 1'b1;
					key_req.rd_addr = scan_cnt_q[KA_W-1:0];
				end
				if (scan_v_s1) begin
					key_req.wr_en   = 1'b1;
					key_req.wr_addr = scan_idx_s1;
					key_req.wr_live = key_rsp.live;
					key_req.wr_hist = scan_hist;
				end
				q_req.push      = ev_push;
				q_req.push_data = ev_byte;
				if (!scan_issue) begin
					next_state = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					next_state = ST_IDLE;
				end
			end
			default: begin
				next_state = ST_IDLE;
			end
		endcase
	end

	// control registers and flags, scan counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_code_q <= 8'h00;
			control_q    <= 8'h00;
			pending_q    <= 1'b0;
			irq_flag_q   <= 1'b0;
			irq_line_q   <= 1'b1;
			scan_cnt_q   <= '0;
			scan_v_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				empty_code_q <= cfg_wdata;
			end
			if (accept && req.command == CMD_WRITE) begin
				if (req.address == ADDR_STATUS && req.write_data[ACK_BIT]) begin
					// interrupt acknowledge
					irq_line_q <= 1'b1;
					irq_flag_q <= 1'b0;
				end else if (req.address == ADDR_CONTROL) begin
					control_q <= req.write_data;
				end
			end
			if (q_req.push) begin
				pending_q <= 1'b1;
				if (control_q[IRQ_EN_BIT]) begin
					irq_line_q <= 1'b0;
					irq_flag_q <= 1'b1;
				end
			end
			if (pend_clr) begin
				pending_q <= 1'b0;
			end
			if (accept) begin
				scan_cnt_q <= '0;
			end else if (state_q == ST_SCAN && scan_issue) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			scan_v_s1 <= (state_q == ST_SCAN) && scan_issue;
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_t'(req.command);
			key_q  <= req.key_index[KA_W-1:0];
			down_q <= req.key_down;
		end
		if (res_ld) begin
			res_q <= res_nxt;
		end
		if (state_q == ST_SCAN) begin
			scan_idx_s1 <= scan_cnt_q[KA_W-1:0];
		end
		if (state_q == ST_RESP && out_free) begin
			out_data_q  <= res_q;
			out_irq_n_q <= irq_line_q;
		end
	end

	// interrupt line and flag always move together
	`KEC_ASSERT_NOW(a_irq_pair, !irq_line_q, irq_flag_q, "irq line low without irq flag")
	// pending flag is only clear when the queue is empty
	`KEC_ASSERT_NOW(a_pending_empty, !pending_q, q_rsp.empty, "events queued but pending clear")
	// write-back stage is only busy during a scan
	`KEC_ASSERT_NOW(a_scan_stage, scan_v_s1, state_q == ST_SCAN, "scan write-back outside scan")
	// a transfer in always starts work
	`KEC_ASSERT_NEXT(a_accept_busy, accept, state_q != ST_IDLE, "idle right after a transfer")
endmodule

/* sim/tb_keyboard_event_controller_core.sv */
// expected results of the keyboard controller, kept in step with accepted commands
class event_scoreboard;
	typedef struct {
		logic [7:0] read_data;
		logic       irq_n;
	} result_t;

	result_t    expected[$];
	logic       key_live[kec_pkg::NUM_KEYS];
	logic [7:0] key_hist[kec_pkg::NUM_KEYS];
	logic [7:0] event_mem[kec_pkg::FIFO_DEPTH];
	logic [kec_pkg::PTR_W-1:0] head;
	logic [kec_pkg::PTR_W-1:0] tail;
	logic       pending;
	logic       irq_flag;
	logic       irq_line;
	logic [7:0] control;
	logic [7:0] empty_code;
	int         mismatches;
	int         results_seen;

	function new();
		foreach (key_live[k]) begin
			key_live[k] = 1'b0;
			key_hist[k] = 8'h00;
		end
		head = '0;
		tail = '0;
		pending = 1'b0;
		irq_flag = 1'b0;
		irq_line = 1'b1;
		control = 8'h00;
		empty_code = 8'h00;
		mismatches = 0;
		results_seen = 0;
	endfunction

	function int queued_events();
		logic [kec_pkg::PTR_W-1:0] n;
		n = head - tail;
		return int'(n);
	endfunction

	function void note_input(kec_pkg::cmd_t cmd, logic [7:0] addr, logic [7:0] wdata,
		logic [6:0] key, logic down);
		logic [7:0] rd;
		logic [7:0] h;
		rd = 8'h00;
		case (cmd)
		kec_pkg::CMD_READ: begin
			if (addr == kec_pkg::ADDR_STATUS) begin
				rd = {irq_flag, 6'b000000, pending};
			end else if (addr == kec_pkg::ADDR_CONTROL) begin
				rd = control;
			end else if (addr == kec_pkg::ADDR_EVENT) begin
				if (head == tail) begin
					rd = empty_code;
				end else begin
					rd = event_mem[tail];
					tail = tail + 1'b1;
					if (head == tail)
						pending = 1'b0;
				end
			end else if (addr[7] && addr[6:0] < kec_pkg::NUM_KEYS) begin
				rd = key_hist[addr[6:0]];
			end
		end
		kec_pkg::CMD_WRITE: begin
			if (addr == kec_pkg::ADDR_STATUS) begin
				if (wdata[kec_pkg::ACK_BIT]) begin
					irq_line = 1'b1;
					irq_flag = 1'b0;
				end
			end else if (addr == kec_pkg::ADDR_CONTROL) begin
				control = wdata;
			end
		end
		kec_pkg::CMD_KEY: begin
			if (key < kec_pkg::NUM_KEYS)
				key_live[key] = down;
		end
		kec_pkg::CMD_SCAN: begin
			for (int k = 0; k < kec_pkg::NUM_KEYS; k++) begin
				h = {key_hist[k][6:0], key_live[k]};
				key_hist[k] = h;
				// 01 is a press, 10 a release with the top bit set
				if (h[1] != h[0]) begin
					event_mem[head] = {h[1], 7'(k)};
					head = head + 1'b1;
					pending = 1'b1;
					if (control[kec_pkg::IRQ_EN_BIT]) begin
						irq_line = 1'b0;
						irq_flag = 1'b1;
					end
				end
			end
		end
		default: begin
		end
		endcase
		expected.push_back('{read_data: rd, irq_n: irq_line});
	endfunction

	function void check_result(logic [7:0] rd, logic irq_n);
		result_t e;
		results_seen++;
		if (expected.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d with nothing expected: read_data=%h irq_n=%b",
					results_seen, rd, irq_n);
		end else begin
			e = expected.pop_front();
			if (rd !== e.read_data || irq_n !== e.irq_n) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d differs: expected read_data=%h irq_n=%b, got read_data=%h irq_n=%b",
						results_seen, e.read_data, e.irq_n, rd, irq_n);
			end
		end
	endfunction
endclass

module tb_keyboard_event_controller_core;
	import kec_pkg::*;

	// slowest correct run stays well under this limit, even if every command were a scan
	localparam int unsigned CYCLE_LIMIT = 2000000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	kec_in_if  req_if ();
	kec_out_if rsp_if ();

	event_scoreboard sb;
	int unsigned     cycles = 0;
	int unsigned     transfers = 0;
	// set while neither side may idle
	bit              quiet_stretch = 1'b0;

	keyboard_event_controller_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	always #6 clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side: check each transfer, then pick ready for the next edge
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
			sb.check_result(rsp_if.read_data, rsp_if.irq_n);
		rsp_if.ready <= quiet_stretch || ($urandom_range(99) >= 7);
	end

	// one command transfer; may first idle the request side
	task automatic bus_transfer(cmd_t cmd, logic [7:0] addr, logic [7:0] wdata,
		logic [6:0] key, logic down);
		if (!quiet_stretch && $urandom_range(99) < 7) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.command    <= cmd;
		req_if.address    <= addr;
		req_if.write_data <= wdata;
		req_if.key_index  <= key;
		req_if.key_down   <= down;
		@(posedge clk);
		while (req_if.ready !== 1'b1) @(posedge clk);
		// transfer taken at this edge; valid stays up unless the caller drops it
		sb.note_input(cmd, addr, wdata, key, down);
		transfers++;
	endtask

	// unused fields carry random values so every input bit toggles
	task automatic bus_read(logic [7:0] addr);
		bus_transfer(CMD_READ, addr, 8'($urandom), 7'($urandom), 1'($urandom));
	endtask

	task automatic bus_write(logic [7:0] addr, logic [7:0] data);
		bus_transfer(CMD_WRITE, addr, data, 7'($urandom), 1'($urandom));
	endtask

	task automatic key_update(int k, logic down);
		bus_transfer(CMD_KEY, 8'($urandom), 8'($urandom), 7'(k), down);
	endtask

	task automatic scan_tick();
		bus_transfer(CMD_SCAN, 8'($urandom), 8'($urandom), 7'($urandom), 1'($urandom));
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain_results();
		req_if.valid <= 1'b0;
		while (sb.expected.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// empty_code only changes while the controller is idle
	task automatic program_empty_code(logic [7:0] code);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= code;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.empty_code = code;
	endtask

	// a few key changes, one or two scans, then mostly a read-out of the events
	task automatic key_activity();
		int unsigned k;
		logic [6:0]  touched;
		touched = '0;
		repeat ($urandom_range(1, 5)) begin
			k = $urandom_range(0, NUM_KEYS - 1);
			touched = 7'(k);
			// mostly real changes of the live state, so scans produce events
			key_update(k, ($urandom_range(99) < 75) ? !sb.key_live[k] : 1'($urandom));
		end
		scan_tick();
		if ($urandom_range(1))
			scan_tick();
		if ($urandom_range(99) < 75) begin
			bus_read(ADDR_STATUS);
			// pop everything queued, sometimes one more to hit the empty case
			repeat (sb.queued_events() + $urandom_range(0, 1)) begin
				bus_read(ADDR_EVENT);
				if ($urandom_range(99) < 15)
					bus_read(8'h80 + 8'(touched));
			end
		end
		if ($urandom_range(99) < 40)
			bus_write(ADDR_STATUS, 8'($urandom));
	endtask

	// push exactly FIFO_DEPTH events with no pop so the write pointer laps the read pointer
	task automatic flood_event_queue();
		// settle keys 0..63 released and empty the queue first
		for (int k = 0; k < 64; k++)
			key_update(k, 1'b0);
		scan_tick();
		scan_tick();
		repeat (sb.queued_events()) bus_read(ADDR_EVENT);
		// press, release, press, release: 4 x 64 events
		for (int pass = 0; pass < 4; pass++) begin
			for (int k = 0; k < 64; k++)
				key_update(k, (pass % 2) == 0);
			scan_tick();
		end
		// queue looks empty now but pending stays set
		bus_read(ADDR_STATUS);
		bus_read(ADDR_EVENT);
		bus_read(ADDR_STATUS);
	endtask

	task automatic random_phase(int unsigned count, bit with_flood);
		int unsigned stop_at;
		int unsigned pick;
		stop_at = transfers + count;
		while (transfers < stop_at) begin
			pick = $urandom_range(99);
			if (with_flood && transfers + count / 2 > stop_at) begin
				flood_event_queue();
				with_flood = 1'b0;
			end else if (pick < 60) begin
				key_activity();
			end else if (pick < 70) begin
				bus_write(ADDR_CONTROL, 8'($urandom));
			end else begin
				// noise: any command with any field values
				bus_transfer(cmd_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
					7'($urandom), 1'($urandom));
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= 8'h00;
		req_if.valid      <= 1'b0;
		req_if.command    <= CMD_READ;
		req_if.address    <= 8'h00;
		req_if.write_data <= 8'h00;
		req_if.key_index  <= 7'h00;
		req_if.key_down   <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_empty_code(8'hFF);

		// directed: register map, both ends of the key range, ack forms, irq on and off
		bus_read(ADDR_STATUS);
		bus_read(ADDR_CONTROL);
		bus_read(ADDR_EVENT);               // pop from an empty queue
		bus_write(ADDR_CONTROL, 8'hFF);     // irq enable
		bus_read(ADDR_CONTROL);
		key_update(0, 1'b1);
		key_update(NUM_KEYS - 1, 1'b1);
		scan_tick();                        // two presses, irq asserted
		bus_read(ADDR_STATUS);
		bus_read(8'h80);
		bus_read(8'hFF);
		bus_read(8'h03);                    // unmapped
		bus_read(8'h7F);                    // unmapped, just below the history window
		bus_write(ADDR_STATUS, 8'hFE);      // ack bit clear: no effect
		bus_read(ADDR_EVENT);
		bus_read(ADDR_EVENT);
		bus_read(ADDR_EVENT);               // empty again
		bus_write(ADDR_STATUS, 8'h01);      // real ack
		bus_write(ADDR_CONTROL, 8'h00);     // irq disabled
		key_update(0, 1'b0);
		key_update(NUM_KEYS - 1, 1'b0);
		scan_tick();                        // releases queued, irq line stays idle
		bus_write(8'h80, 8'h55);            // write outside the map is ignored
		bus_read(ADDR_EVENT);
		bus_read(ADDR_EVENT);

		random_phase(400, 1'b0);

		program_empty_code(8'h00);
		quiet_stretch = 1'b1;
		random_phase(450, 1'b0);
		quiet_stretch = 1'b0;

		program_empty_code(8'($urandom_range(1, 254)));
		random_phase(450, 1'b1);

		program_empty_code(8'h7F);
		random_phase(450, 1'b0);

		drain_results();
		if (sb.mismatches == 0 && sb.expected.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
